// ----- sv/assert_macros.svh -----
// Assertion helpers for the checker; both sample on clk and stay quiet in reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define CHK_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define CHK_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- sv/gpfp_pkg.sv -----
`timescale 1ns / 1ps
package gpfp_pkg;

  localparam logic [7:0] SYNC_FIRST  = 8'hB5;
  localparam logic [7:0] SYNC_SECOND = 8'h62;
  localparam logic [7:0] CLASS_RESET = 8'h01;
  localparam logic [7:0] ID_RESET    = 8'h02;

  localparam int FIELD_COUNT = 7;
  localparam int FIELD_IDX_W = $clog2(FIELD_COUNT);
  localparam logic [15:0] MIN_PAYLOAD = 16'd28;

  localparam int CFG_IDX_W = 8;
  localparam logic [CFG_IDX_W-1:0] REG_EXPECTED_CLASS = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_EXPECTED_ID    = 8'd1;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_BAD_CKSUM = 2'd1;
  localparam logic [1:0] ST_SHORT     = 2'd2;

  localparam int OUT_BITS   = 2 + 16 + 32 * FIELD_COUNT;
  localparam int OUT_DATA_W = ((OUT_BITS + 7) / 8) * 8;

  typedef enum logic [3:0] {
    PH_SYNC1,
    PH_SYNC2,
    PH_CLASS,
    PH_ID,
    PH_LEN_LO,
    PH_LEN_HI,
    PH_PAYLOAD,
    PH_CK_A,
    PH_CK_B
  } phase_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [15:0] payload_length;
    logic [31:0] time_of_week;
    logic signed [31:0] longitude;
    logic signed [31:0] latitude;
    logic signed [31:0] ellipsoid_height;
    logic signed [31:0] sea_level_height;
    logic [31:0] horizontal_accuracy;
    logic [31:0] vertical_accuracy;
  } result_t;

endpackage

// ----- sv/gpfp_parse_core.sv -----
`timescale 1ns / 1ps
module gpfp_parse_core (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             en,
  input  logic [7:0]       data_b,
  input  logic [7:0]       exp_class,
  input  logic [7:0]       exp_id,
  output logic             res_valid,
  output gpfp_pkg::result_t res
);
  import gpfp_pkg::*;

  phase_t      phase_r, phase_nxt;
  logic [15:0] byte_counter_r, byte_counter_nxt;
  logic [15:0] frame_length_r, frame_length_nxt;
  logic [7:0]  sum_a_r, sum_a_nxt;
  logic [7:0]  sum_b_r, sum_b_nxt;
  logic [7:0]  first_check_r, first_check_nxt;
  logic [31:0] fields_r [FIELD_COUNT];

  logic [7:0]  base_a, base_b, add_a, add_b;
  logic [15:0] cnt_inc, len_full;
  logic        short_p, good;
  logic        cap_en;
  logic [FIELD_IDX_W-1:0] cap_idx;
  logic [1:0]  cap_lane;

  // Fletcher step; the class byte restarts the sums.
  assign base_a  = (phase_r == PH_CLASS) ? 8'd0 : sum_a_r;
  assign base_b  = (phase_r == PH_CLASS) ? 8'd0 : sum_b_r;
  assign add_a   = base_a + data_b;
  assign add_b   = base_b + add_a;
  assign cnt_inc = byte_counter_r + 16'd1;
  assign len_full = {data_b, frame_length_r[7:0]};

  assign cap_en   = en && (phase_r == PH_PAYLOAD) && (byte_counter_r < MIN_PAYLOAD);
  assign cap_idx  = byte_counter_r[FIELD_IDX_W+1:2];
  assign cap_lane = byte_counter_r[1:0];

  assign short_p = frame_length_r < MIN_PAYLOAD;
  assign good    = (first_check_r == sum_a_r) && (data_b == sum_b_r);

  always_comb begin
    phase_nxt        = phase_r;
    byte_counter_nxt = byte_counter_r;
    frame_length_nxt = frame_length_r;
    sum_a_nxt        = sum_a_r;
    sum_b_nxt        = sum_b_r;
    first_check_nxt  = first_check_r;
    res_valid        = 1'b0;
    case (phase_r)
      PH_SYNC1: begin
        if (data_b == SYNC_FIRST) phase_nxt = PH_SYNC2;
      end
      PH_SYNC2: begin
        phase_nxt = (data_b == SYNC_SECOND) ? PH_CLASS : PH_SYNC1;
      end
      PH_CLASS: begin
        if (data_b == exp_class) begin
          sum_a_nxt = add_a;
          sum_b_nxt = add_b;
          phase_nxt = PH_ID;
        end else begin
          phase_nxt = PH_SYNC1;
        end
      end
      PH_ID: begin
        if (data_b == exp_id) begin
          sum_a_nxt = add_a;
          sum_b_nxt = add_b;
          phase_nxt = PH_LEN_LO;
        end else begin
          phase_nxt = PH_SYNC1;
        end
      end
      PH_LEN_LO: begin
        sum_a_nxt        = add_a;
        sum_b_nxt        = add_b;
        frame_length_nxt = {8'd0, data_b};
        phase_nxt        = PH_LEN_HI;
      end
      PH_LEN_HI: begin
        sum_a_nxt        = add_a;
        sum_b_nxt        = add_b;
        frame_length_nxt = len_full;
        byte_counter_nxt = 16'd0;
        phase_nxt        = (len_full == 16'd0) ? PH_CK_A : PH_PAYLOAD;
      end
      PH_PAYLOAD: begin
        sum_a_nxt        = add_a;
        sum_b_nxt        = add_b;
        byte_counter_nxt = cnt_inc;
        if (cnt_inc >= frame_length_r) phase_nxt = PH_CK_A;
      end
      PH_CK_A: begin
        first_check_nxt = data_b;
        phase_nxt       = PH_CK_B;
      end
      PH_CK_B: begin
        res_valid = 1'b1;
        phase_nxt = PH_SYNC1;
      end
      default: phase_nxt = PH_SYNC1;
    endcase
  end

  always_comb begin
    res.status              = short_p ? ST_SHORT : (good ? ST_OK : ST_BAD_CKSUM);
    res.payload_length      = frame_length_r;
    res.time_of_week        = short_p ? 32'd0 : fields_r[0];
    res.longitude           = short_p ? 32'd0 : fields_r[1];
    res.latitude            = short_p ? 32'd0 : fields_r[2];
    res.ellipsoid_height    = short_p ? 32'd0 : fields_r[3];
    res.sea_level_height    = short_p ? 32'd0 : fields_r[4];
    res.horizontal_accuracy = short_p ? 32'd0 : fields_r[5];
    res.vertical_accuracy   = short_p ? 32'd0 : fields_r[6];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r        <= PH_SYNC1;
      byte_counter_r <= '0;
      frame_length_r <= '0;
      sum_a_r        <= '0;
      sum_b_r        <= '0;
      first_check_r  <= '0;
    end else if (en) begin
      phase_r        <= phase_nxt;
      byte_counter_r <= byte_counter_nxt;
      frame_length_r <= frame_length_nxt;
      sum_a_r        <= sum_a_nxt;
      sum_b_r        <= sum_b_nxt;
      first_check_r  <= first_check_nxt;
    end
  end

  // Payload capture: one byte lane of one field per payload byte, for the first MIN_PAYLOAD bytes only.
  always_ff @(posedge clk) begin
    if (cap_en) begin
      fields_r[cap_idx][8*cap_lane +: 8] <= data_b;
    end
  end

endmodule

// ----- sv/gpfp_out_stage.sv -----
`timescale 1ns / 1ps
module gpfp_out_stage (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              load,
  input  logic              load_valid,
  input  gpfp_pkg::result_t load_res,
  input  logic              out_ready,
  output logic              out_valid,
  output gpfp_pkg::result_t out_res,
  output logic              advance
);
  import gpfp_pkg::*;

  logic    out_valid_r;
  result_t out_res_r;

  // Move on when the result slot is empty or being emptied this cycle.
  assign advance   = !out_valid_r || out_ready;
  assign out_valid = out_valid_r;
  assign out_res   = out_res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= load && load_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && load && load_valid) begin
      out_res_r <= load_res;
    end
  end

endmodule

// ----- sv/gnss_position_frame_parser.sv -----
`timescale 1ns / 1ps
// Path: the second checksum byte of a frame is taken into the input register,
//   and the frame's result then into the result register once that slot is free.
// Throughput: one byte per cycle; in_tready drops only while a result is stalled.
// Reset: synchronous, active low; parser hunts for sync, registers go to
//   class 0x01 and id 0x02, no result pending.
module gnss_position_frame_parser (
  input  logic                            clk,
  input  logic                            rst_n,
  // tdata: [7:0] data_byte
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [7:0]                      in_tdata,
  // tdata: [1:0] status, [17:2] payload_length, [49:18] time_of_week,
  //   [81:50] longitude, [113:82] latitude, [145:114] ellipsoid_height,
  //   [177:146] sea_level_height, [209:178] horizontal_accuracy,
  //   [241:210] vertical_accuracy, [247:242] zero fill
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [gpfp_pkg::OUT_DATA_W-1:0] out_tdata,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [gpfp_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [7:0]                      cfg_data
);
  import gpfp_pkg::*;

  logic       in_valid_r;
  logic [7:0] in_byte_r;
  logic [7:0] exp_class_r;
  logic [7:0] exp_id_r;
  logic       advance;
  logic       core_en;
  logic       res_valid;
  result_t    res;
  result_t    out_res;

  // Config writes are registered directly; never stall them.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      exp_class_r <= CLASS_RESET;
      exp_id_r    <= ID_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_EXPECTED_CLASS: exp_class_r <= cfg_data;
        REG_EXPECTED_ID:    exp_id_r    <= cfg_data;
        default: ;
      endcase
    end
  end

  // Input register: refill whenever it is empty or the held byte is consumed this cycle.
  assign in_tready = !in_valid_r || advance;
  assign core_en   = in_valid_r && advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      in_byte_r <= in_tdata;
    end
  end

  // Frame state, checksum and field capture run on each consumed byte.
  gpfp_parse_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (core_en),
    .data_b    (in_byte_r),
    .exp_class (exp_class_r),
    .exp_id    (exp_id_r),
    .res_valid (res_valid),
    .res       (res)
  );

  // Result register: holds a finished item while the sink stalls.
  gpfp_out_stage u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (core_en),
    .load_valid (res_valid),
    .load_res   (res),
    .out_ready  (out_tready),
    .out_valid  (out_tvalid),
    .out_res    (out_res),
    .advance    (advance)
  );

  // Pack fields, first field in the lowest bits, zero fill to a byte boundary.
  assign out_tdata = {{(OUT_DATA_W - OUT_BITS){1'b0}},
                      out_res.vertical_accuracy,
                      out_res.horizontal_accuracy,
                      out_res.sea_level_height,
                      out_res.ellipsoid_height,
                      out_res.latitude,
                      out_res.longitude,
                      out_res.time_of_week,
                      out_res.payload_length,
                      out_res.status};

endmodule

// ----- sv/gpfp_checker.sv -----
`timescale 1ns / 1ps
`include "assert_macros.svh"
module gpfp_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_tvalid,
  input logic                            in_tready,
  input logic [7:0]                      in_tdata,
  input logic                            out_tvalid,
  input logic                            out_tready,
  input logic [gpfp_pkg::OUT_DATA_W-1:0] out_tdata,
  input logic                            cfg_valid,
  input logic                            cfg_ready,
  input logic [gpfp_pkg::CFG_IDX_W-1:0]  cfg_index,
  input logic [7:0]                      cfg_data
);
  import gpfp_pkg::*;

  logic [1:0]  st;
  logic [15:0] len;
  logic        used;

  assign st   = out_tdata[1:0];
  assign len  = out_tdata[17:2];
  // Tie off ports that no property needs.
  assign used = |{in_tvalid, in_tready, in_tdata, cfg_valid, cfg_ready, cfg_index, cfg_data};

  `CHK_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata),
            "result changed while stalled")
  `CHK_IMPL(a_short_status, out_tvalid, (len < MIN_PAYLOAD) == (st == ST_SHORT),
            "short status does not follow payload length")
  `CHK_IMPL(a_short_zero, out_tvalid && st == ST_SHORT, out_tdata[OUT_BITS-1:18] == '0,
            "short frame carries nonzero fields")
  `CHK_IMPL(a_status_code, out_tvalid, st == ST_OK || st == ST_BAD_CKSUM || st == ST_SHORT,
            "illegal status code")
  `CHK_IMPL(a_pad_zero, out_tvalid || used, out_tdata[OUT_DATA_W-1:OUT_BITS] == '0,
            "fill bits not zero")

endmodule

bind gnss_position_frame_parser gpfp_checker u_gpfp_checker (.*);

// ----- dv/gpfp_frame_checker.sv -----
`timescale 1ns / 1ps
module gpfp_frame_checker (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  input  logic                            in_tready,
  input  logic [7:0]                      in_tdata,
  input  logic                            out_tvalid,
  input  logic                            out_tready,
  input  logic [gpfp_pkg::OUT_DATA_W-1:0] out_tdata,
  input  logic                            cfg_valid,
  input  logic                            cfg_ready,
  input  logic [gpfp_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [7:0]                      cfg_data,
  output int                              fail_total,
  output int                              reports_due
);
  import gpfp_pkg::*;

  logic [7:0]  want_class;
  logic [7:0]  want_id;
  phase_t      phase;
  logic [15:0] payload_pos;
  logic [15:0] frame_len;
  logic [7:0]  sum_a;
  logic [7:0]  sum_b;
  logic [7:0]  ck_a_seen;
  logic [31:0] field_word [FIELD_COUNT];
  result_t     reports_q [$];
  result_t     due;

  task automatic mix_in(input logic [7:0] b);
    sum_a = sum_a + b;
    sum_b = sum_b + sum_a;
  endtask

  // Advance the frame parse by one byte; queue a report when a frame completes.
  task automatic parse_byte(input logic [7:0] b);
    result_t rpt;
    case (phase)
      PH_SYNC1: if (b == SYNC_FIRST) phase = PH_SYNC2;
      PH_SYNC2: phase = (b == SYNC_SECOND) ? PH_CLASS : PH_SYNC1;
      PH_CLASS: begin
        if (b == want_class) begin
          sum_a = 8'd0;
          sum_b = 8'd0;
          mix_in(b);
          phase = PH_ID;
        end else begin
          phase = PH_SYNC1;
        end
      end
      PH_ID: begin
        if (b == want_id) begin
          mix_in(b);
          phase = PH_LEN_LO;
        end else begin
          phase = PH_SYNC1;
        end
      end
      PH_LEN_LO: begin
        mix_in(b);
        frame_len = {8'd0, b};
        phase = PH_LEN_HI;
      end
      PH_LEN_HI: begin
        mix_in(b);
        frame_len[15:8] = b;
        payload_pos = 16'd0;
        phase = (frame_len == 16'd0) ? PH_CK_A : PH_PAYLOAD;
      end
      PH_PAYLOAD: begin
        mix_in(b);
        // only the first seven words are kept, little-endian
        if (payload_pos < MIN_PAYLOAD)
          field_word[payload_pos[4:2]][{payload_pos[1:0], 3'b000} +: 8] = b;
        payload_pos = payload_pos + 16'd1;
        if (payload_pos >= frame_len) phase = PH_CK_A;
      end
      PH_CK_A: begin
        ck_a_seen = b;
        phase = PH_CK_B;
      end
      PH_CK_B: begin
        if (frame_len < MIN_PAYLOAD)
          rpt.status = ST_SHORT;
        else if (ck_a_seen == sum_a && b == sum_b)
          rpt.status = ST_OK;
        else
          rpt.status = ST_BAD_CKSUM;
        rpt.payload_length = frame_len;
        if (frame_len < MIN_PAYLOAD) begin
          rpt.time_of_week        = '0;
          rpt.longitude           = '0;
          rpt.latitude            = '0;
          rpt.ellipsoid_height    = '0;
          rpt.sea_level_height    = '0;
          rpt.horizontal_accuracy = '0;
          rpt.vertical_accuracy   = '0;
        end else begin
          rpt.time_of_week        = field_word[0];
          rpt.longitude           = field_word[1];
          rpt.latitude            = field_word[2];
          rpt.ellipsoid_height    = field_word[3];
          rpt.sea_level_height    = field_word[4];
          rpt.horizontal_accuracy = field_word[5];
          rpt.vertical_accuracy   = field_word[6];
        end
        reports_q.push_back(rpt);
        phase = PH_SYNC1;
      end
      default: phase = PH_SYNC1;
    endcase
  endtask

  task automatic compare_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
    if (got !== want) begin
      fail_total++;
      $display("%0t: %s mismatch, expected 0x%08h, got 0x%08h", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      want_class  = CLASS_RESET;
      want_id     = ID_RESET;
      phase       = PH_SYNC1;
      payload_pos = 16'd0;
      frame_len   = 16'd0;
      sum_a       = 8'd0;
      sum_b       = 8'd0;
      ck_a_seen   = 8'd0;
      for (int i = 0; i < FIELD_COUNT; i++) field_word[i] = 32'd0;
      reports_q.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_EXPECTED_CLASS: want_class = cfg_data;
          REG_EXPECTED_ID:    want_id    = cfg_data;
          default: ;
        endcase
      end
      // compare first: a result leaving now belongs to an earlier frame
      if (out_tvalid && out_tready) begin
        if (reports_q.size() == 0) begin
          fail_total++;
          $display("%0t: unexpected result, expected none, got 0x%h", $time, out_tdata);
        end else begin
          due = reports_q.pop_front();
          compare_field("status",         32'(due.status),         32'(out_tdata[1:0]));
          compare_field("payload_length", 32'(due.payload_length), 32'(out_tdata[17:2]));
          compare_field("time_of_week",        due.time_of_week,        out_tdata[49:18]);
          compare_field("longitude",           due.longitude,           out_tdata[81:50]);
          compare_field("latitude",            due.latitude,            out_tdata[113:82]);
          compare_field("ellipsoid_height",    due.ellipsoid_height,    out_tdata[145:114]);
          compare_field("sea_level_height",    due.sea_level_height,    out_tdata[177:146]);
          compare_field("horizontal_accuracy", due.horizontal_accuracy, out_tdata[209:178]);
          compare_field("vertical_accuracy",   due.vertical_accuracy,   out_tdata[241:210]);
        end
      end
      if (in_tvalid && in_tready) parse_byte(in_tdata);
    end
    reports_due = reports_q.size();
  end

endmodule

// ----- dv/tb_gnss_position_frame_parser.sv -----
`timescale 1ns / 1ps
module tb_gnss_position_frame_parser;
  import gpfp_pkg::*;

  // Abort the run if it gets this far.
  localparam int CYCLE_LIMIT = 1000000;
  // Length of the long receiver hold-off used to back the block up.
  localparam int LONG_HOLD = 300;

  // How a generated frame is spoiled.
  localparam int FAULT_NONE = 0;
  localparam int FAULT_CK_A = 1;  // corrupt the first checksum byte
  localparam int FAULT_CK_B = 2;  // corrupt the second checksum byte
  localparam int FAULT_CUT  = 3;  // stop partway through the payload

  // How payload bytes are filled.
  localparam int FILL_RANDOM = 0;
  localparam int FILL_ZERO   = 1;
  localparam int FILL_ONES   = 2;
  localparam int FILL_MIN    = 3;  // every word 0x80000000
  localparam int FILL_MAX    = 4;  // every word 0x7fffffff

  logic clk = 1'b0;
  logic rst_n;

  logic                   in_tvalid;
  logic                   in_tready;
  logic [7:0]             in_tdata;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_DATA_W-1:0]  out_tdata;
  logic                   cfg_valid;
  logic                   cfg_ready;
  logic [CFG_IDX_W-1:0]   cfg_index;
  logic [7:0]             cfg_data;

  int fail_total;
  int reports_due;

  int cycle_count = 0;
  int tx_idle_pct = 20;
  int rx_idle_pct = 57;
  int hold_requests = 0;
  int holds_served = 0;
  int hold_left = 0;
  int bytes_sent = 0;

  // Header values the generator uses for well-formed frames; track the registers.
  logic [7:0] cur_class = CLASS_RESET;
  logic [7:0] cur_id    = ID_RESET;

  gnss_position_frame_parser uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  gpfp_frame_checker frame_chk (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .fail_total  (fail_total),
    .reports_due (reports_due)
  );

  always #5 clk = ~clk;

  // Watchdog: end the run if the block hangs.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // Result side: random backpressure, plus a long hold-off whenever the
  // stimulus asks for one. The hold is counted here, independent of the sender.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (hold_left != 0) begin
      out_tready <= 1'b0;
      hold_left  <= hold_left - 1;
    end else if (holds_served != hold_requests) begin
      holds_served <= holds_served + 1;
      hold_left    <= LONG_HOLD;
      out_tready   <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  // Offer one byte, with random idle cycles ahead of it; hold it until accepted.
  task automatic send_byte(input logic [7:0] b);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    bytes_sent++;
  endtask

  function automatic logic [7:0] fill_byte(input int fill, input int pos);
    case (fill)
      FILL_ZERO: return 8'h00;
      FILL_ONES: return 8'hFF;
      FILL_MIN:  return (pos % 4 == 3) ? 8'h80 : 8'h00;
      FILL_MAX:  return (pos % 4 == 3) ? 8'h7F : 8'hFF;
      default:   return 8'($urandom);
    endcase
  endfunction

  // Build and send a whole frame, computing its checksum on the way.
  task automatic send_frame(input logic [7:0] cls, input logic [7:0] id,
                            input logic [15:0] len, input int fault, input int fill);
    logic [7:0] ck_a;
    logic [7:0] ck_b;
    logic [7:0] b;
    int         stop_at;
    ck_a = 8'd0;
    ck_b = 8'd0;
    stop_at = (fault == FAULT_CUT && len != 0) ? $urandom_range(len - 1) : len;
    send_byte(SYNC_FIRST);
    send_byte(SYNC_SECOND);
    for (int i = 0; i < 4; i++) begin
      case (i)
        0:       b = cls;
        1:       b = id;
        2:       b = len[7:0];
        default: b = len[15:8];
      endcase
      ck_a = ck_a + b;
      ck_b = ck_b + ck_a;
      send_byte(b);
    end
    for (int i = 0; i < stop_at; i++) begin
      b = fill_byte(fill, i);
      ck_a = ck_a + b;
      ck_b = ck_b + ck_a;
      send_byte(b);
    end
    if (fault == FAULT_CUT) return;
    if (fault == FAULT_CK_A) ck_a = ck_a ^ 8'($urandom_range(255, 1));
    if (fault == FAULT_CK_B) ck_b = ck_b ^ 8'($urandom_range(255, 1));
    send_byte(ck_a);
    send_byte(ck_b);
  endtask

  // Drop valid and wait until every predicted result is out, then let the
  // block settle. Sampled on the falling edge to stay clear of the updates
  // made at the rising edge.
  task automatic drain();
    in_tvalid <= 1'b0;
    @(negedge clk);
    while (reports_due != 0) @(negedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    @(posedge clk);
    if (idx == REG_EXPECTED_CLASS) cur_class = val;
    if (idx == REG_EXPECTED_ID) cur_id = val;
  endtask

  function automatic logic [15:0] pick_length();
    int roll;
    roll = $urandom_range(99);
    if (roll < 50) return MIN_PAYLOAD;
    if (roll < 72) return 16'($urandom_range(27));
    if (roll < 92) return 16'($urandom_range(60, 29));
    return 16'($urandom_range(300, 61));
  endfunction

  function automatic int pick_fault();
    int roll;
    roll = $urandom_range(99);
    if (roll < 76) return FAULT_NONE;
    if (roll < 88) return FAULT_CK_A;
    return FAULT_CK_B;
  endfunction

  function automatic int pick_fill();
    return ($urandom_range(9) < 7) ? FILL_RANDOM : $urandom_range(FILL_MAX, FILL_ZERO);
  endfunction

  function automatic logic [7:0] other_than(input logic [7:0] v);
    logic [7:0] b;
    b = 8'($urandom);
    if (b == v) b = ~v;
    return b;
  endfunction

  // Mostly well-formed frames with random content; the rest is line noise,
  // broken sync, foreign class or id, and frames cut short.
  task automatic random_traffic(input int byte_goal, input int frame_goal);
    int first_byte;
    int frames;
    int roll;
    first_byte = bytes_sent;
    frames = 0;
    while (bytes_sent - first_byte < byte_goal || frames < frame_goal) begin
      roll = $urandom_range(99);
      if (roll < 70) begin
        send_frame(cur_class, cur_id, pick_length(), pick_fault(), pick_fill());
        frames++;
      end else if (roll < 78) begin
        repeat ($urandom_range(8, 1)) send_byte(8'($urandom));
      end else if (roll < 84) begin
        send_byte(SYNC_FIRST);
        send_byte(($urandom_range(1)) ? SYNC_FIRST : other_than(SYNC_SECOND));
      end else if (roll < 90) begin
        send_byte(SYNC_FIRST);
        send_byte(SYNC_SECOND);
        send_byte(other_than(cur_class));
      end else if (roll < 95) begin
        send_byte(SYNC_FIRST);
        send_byte(SYNC_SECOND);
        send_byte(cur_class);
        send_byte(other_than(cur_id));
      end else begin
        send_frame(cur_class, cur_id, 16'($urandom_range(60, 1)), FAULT_CUT, FILL_RANDOM);
      end
    end
  endtask

  initial begin
    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tdata  = 8'd0;
    cfg_valid = 1'b0;
    cfg_index = REG_EXPECTED_CLASS;
    cfg_data  = 8'd0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Phase one: sender idles a fifth of the time, receiver more than half.
    // Directed frames run against the reset class and id.
    send_frame(cur_class, cur_id, MIN_PAYLOAD, FAULT_NONE, FILL_ONES);
    send_frame(cur_class, cur_id, MIN_PAYLOAD, FAULT_NONE, FILL_ZERO);
    send_frame(cur_class, cur_id, MIN_PAYLOAD, FAULT_NONE, FILL_MIN);
    send_frame(cur_class, cur_id, MIN_PAYLOAD, FAULT_CK_A, FILL_MAX);
    send_frame(cur_class, cur_id, MIN_PAYLOAD, FAULT_CK_B, FILL_RANDOM);
    // zero length goes straight to the checksum
    send_frame(cur_class, cur_id, 16'd0, FAULT_NONE, FILL_RANDOM);
    send_frame(cur_class, cur_id, 16'd0, FAULT_CK_B, FILL_RANDOM);
    // short payloads report short whatever the checksum
    send_frame(cur_class, cur_id, MIN_PAYLOAD - 16'd1, FAULT_NONE, FILL_ONES);
    send_frame(cur_class, cur_id, 16'd1, FAULT_CK_A, FILL_RANDOM);
    // long payloads: extra bytes only feed the checksum
    send_frame(cur_class, cur_id, MIN_PAYLOAD + 16'd1, FAULT_NONE, FILL_RANDOM);
    send_frame(cur_class, cur_id, 16'd64, FAULT_CK_A, FILL_RANDOM);
    // second sync byte wrong and itself a first sync byte: it must not restart sync
    send_byte(SYNC_FIRST);
    send_frame(cur_class, cur_id, MIN_PAYLOAD, FAULT_NONE, FILL_RANDOM);
    send_frame(cur_class, cur_id, MIN_PAYLOAD, FAULT_NONE, FILL_RANDOM);
    send_byte(SYNC_FIRST);
    send_byte(8'h00);
    // foreign class, then foreign id: both dropped silently
    send_byte(SYNC_FIRST);
    send_byte(SYNC_SECOND);
    send_byte(other_than(cur_class));
    send_frame(cur_class, cur_id, MIN_PAYLOAD, FAULT_NONE, FILL_RANDOM);
    send_byte(SYNC_FIRST);
    send_byte(SYNC_SECOND);
    send_byte(cur_class);
    send_byte(other_than(cur_id));
    send_frame(cur_class, cur_id, 16'd5, FAULT_NONE, FILL_RANDOM);
    random_traffic(120, 3);
    drain();

    // Phase two: roles swapped, registers at their extremes.
    tx_idle_pct = 57;
    rx_idle_pct <= 20;
    write_reg(REG_EXPECTED_CLASS, 8'h00);
    write_reg(REG_EXPECTED_ID, 8'hFF);
    random_traffic(120, 3);
    drain();
    write_reg(REG_EXPECTED_CLASS, 8'hFF);
    write_reg(REG_EXPECTED_ID, 8'h00);
    random_traffic(120, 3);
    drain();

    // Phase three: no idling on either side.
    tx_idle_pct = 0;
    rx_idle_pct <= 0;
    write_reg(REG_EXPECTED_CLASS, 8'($urandom));
    write_reg(REG_EXPECTED_ID, 8'($urandom));
    // Hold the result side off for a long stretch while short frames keep
    // coming, so the block backs up and stalls its input.
    hold_requests <= hold_requests + 1;
    repeat (10) send_frame(cur_class, cur_id, 16'($urandom_range(27)), pick_fault(),
                           FILL_RANDOM);
    random_traffic(120, 3);
    // Pause the sender until every result is out, then go on.
    drain();
    random_traffic(120, 3);
    drain();

    repeat (8) @(posedge clk);
    @(negedge clk);
    if (fail_total == 0 && reports_due == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
